FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CHECK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/core/dlts_pkg.sv
// Shared constants, types and packing for the display line timing sequencer.
// No dependencies.
package dlts_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 144;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 56;
    localparam int ACC_W       = 28;
    localparam int NUM_ACC     = 4;

    localparam logic [8:0] VISIBLE_LINES = 9'd160;
    localparam logic [8:0] TOTAL_LINES   = 9'd227;

    localparam logic [10:0] WAIT_DRAW   = 11'd960;
    localparam logic [10:0] WAIT_HBLANK = 11'd272;
    localparam logic [10:0] WAIT_VBLANK = 11'd1232;

    localparam logic [1:0] PH_DRAW   = 2'd0;
    localparam logic [1:0] PH_HBLANK = 2'd1;
    localparam logic [1:0] PH_VBLANK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_MATCH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IRQ_EN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BG2_DELTA  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BG3_DELTA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BG2_REF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BG3_REF    = 3'd5;

    localparam int IRQ_VBLANK = 0;
    localparam int IRQ_HBLANK = 1;
    localparam int IRQ_MATCH  = 2;

    typedef struct packed {
        logic add;
        logic reload;
    } aff_ctrl_t;

    typedef struct packed {
        logic        render_line;
        logic        vblank_dma;
        logic        hblank_dma;
        logic [2:0]  irq_raise;
        logic        line_match;
        logic [10:0] wait_length;
        logic [7:0]  line_count;
        logic [1:0]  phase_now;
    } tm_result_t;

    typedef logic [NUM_ACC-1:0][ACC_W-1:0] acc_vec_t;

    function automatic logic [OUT_TDATA_W-1:0] pack_result(tm_result_t r, acc_vec_t acc);
        pack_result = {4'b0, acc[3], acc[2], acc[1], acc[0], r};
    endfunction

endpackage

FILE: rtl/core/dlts_timing.sv
// Phase sequencer, line counter, DMA flags and interrupt pulses.
// Depends on dlts_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dlts_timing
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             line_match_value,
    input  logic [2:0]             irq_enables,
    output dlts_pkg::tm_result_t   result,
    output dlts_pkg::aff_ctrl_t    aff_ctrl
);

    logic [1:0] phase_reg, phase_next;
    logic [7:0] line_reg, line_next;
    logic       hdma_reg, hdma_next;
    logic       vdma_reg, vdma_next;
    logic       match;
    logic [8:0] line_inc;
    logic [2:0] irq;
    logic [10:0] wait_len;
    logic       render;

    assign match    = (line_reg == line_match_value);
    assign line_inc = {1'b0, line_reg} + 9'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        line_next       = line_reg;
        hdma_next       = hdma_reg;
        vdma_next       = vdma_reg;
        irq             = 3'b000;
        wait_len        = dlts_pkg::WAIT_DRAW;
        render          = 1'b0;
        aff_ctrl.add    = 1'b0;
        aff_ctrl.reload = 1'b0;
        unique case (phase_reg)
            dlts_pkg::PH_DRAW:
            begin
                hdma_next    = 1'b1;
                phase_next   = dlts_pkg::PH_HBLANK;
                wait_len     = dlts_pkg::WAIT_HBLANK;
                aff_ctrl.add = 1'b1;
                irq[dlts_pkg::IRQ_HBLANK] = irq_enables[dlts_pkg::IRQ_HBLANK];
                render       = 1'b1;
            end
            dlts_pkg::PH_HBLANK:
            begin
                line_next = line_inc[7:0];
                hdma_next = 1'b0;
                irq[dlts_pkg::IRQ_MATCH] = match & irq_enables[dlts_pkg::IRQ_MATCH];
                if (line_inc == dlts_pkg::VISIBLE_LINES)
                begin
                    aff_ctrl.reload = 1'b1;
                    vdma_next       = 1'b1;
                    phase_next      = dlts_pkg::PH_VBLANK;
                    wait_len        = dlts_pkg::WAIT_VBLANK;
                    irq[dlts_pkg::IRQ_VBLANK] = irq_enables[dlts_pkg::IRQ_VBLANK];
                end
                else
                begin
                    phase_next = dlts_pkg::PH_DRAW;
                    wait_len   = dlts_pkg::WAIT_DRAW;
                end
            end
            default:
            begin
                line_next = line_inc[7:0];
                irq[dlts_pkg::IRQ_MATCH] = match & irq_enables[dlts_pkg::IRQ_MATCH];
                if (line_inc == dlts_pkg::TOTAL_LINES)
                begin
                    vdma_next  = 1'b0;
                    phase_next = dlts_pkg::PH_DRAW;
                    wait_len   = dlts_pkg::WAIT_DRAW;
                    line_next  = 8'd0;
                end
                else
                begin
                    phase_next = dlts_pkg::PH_VBLANK;
                    wait_len   = dlts_pkg::WAIT_VBLANK;
                end
            end
        endcase
    end

    always_comb
    begin
        result.phase_now   = phase_next;
        result.line_count  = line_next;
        result.wait_length = wait_len;
        result.line_match  = match;
        result.irq_raise   = irq;
        result.hblank_dma  = hdma_next;
        result.vblank_dma  = vdma_next;
        result.render_line = render;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dlts_pkg::PH_DRAW;
            line_reg  <= 8'd0;
            hdma_reg  <= 1'b0;
            vdma_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            line_reg  <= line_next;
            hdma_reg  <= hdma_next;
            vdma_reg  <= vdma_next;
        end
    end

    `ASSERT_CHECK(a_hdma_tracks_phase, hdma_reg == (phase_reg == dlts_pkg::PH_HBLANK), "hblank DMA flag out of step with phase")
    `ASSERT_CHECK(a_vdma_tracks_phase, vdma_reg == (phase_reg == dlts_pkg::PH_VBLANK), "vblank DMA flag out of step with phase")
    `ASSERT_CHECK(a_draw_to_hblank, step && phase_reg == dlts_pkg::PH_DRAW |=> phase_reg == dlts_pkg::PH_HBLANK, "draw line step did not enter hblank")
    `ASSERT_NEVER(a_line_in_view, phase_reg != dlts_pkg::PH_VBLANK && {1'b0, line_reg} >= dlts_pkg::VISIBLE_LINES, "line counter past visible area outside vblank")

endmodule

FILE: rtl/core/dlts_affine.sv
// Affine reference point accumulators for backgrounds 2 and 3.
// Depends on dlts_pkg.
module dlts_affine
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  dlts_pkg::aff_ctrl_t aff_ctrl,
    input  logic [31:0]         bg2_line_deltas,
    input  logic [31:0]         bg3_line_deltas,
    input  logic [55:0]         bg2_reference,
    input  logic [55:0]         bg3_reference,
    output dlts_pkg::acc_vec_t  acc_next
);

    dlts_pkg::acc_vec_t           acc_reg;
    logic [dlts_pkg::NUM_ACC-1:0][15:0] delta;
    dlts_pkg::acc_vec_t           ref_val;

    assign delta[0]   = bg2_line_deltas[15:0];
    assign delta[1]   = bg2_line_deltas[31:16];
    assign delta[2]   = bg3_line_deltas[15:0];
    assign delta[3]   = bg3_line_deltas[31:16];
    assign ref_val[0] = bg2_reference[27:0];
    assign ref_val[1] = bg2_reference[55:28];
    assign ref_val[2] = bg3_reference[27:0];
    assign ref_val[3] = bg3_reference[55:28];

    always_comb
    begin
        for (int i = 0; i < dlts_pkg::NUM_ACC; i++)
        begin
            priority if (aff_ctrl.reload)
                acc_next[i] = ref_val[i];
            else if (aff_ctrl.add)
                acc_next[i] = acc_reg[i] + {{(dlts_pkg::ACC_W-16){delta[i][15]}}, delta[i]};
            else
                acc_next[i] = acc_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (step)
            acc_reg <= acc_next;
    end

endmodule

FILE: rtl/core/display_line_timing_sequencer.sv
// Top level of the display line timing sequencer: stream ports, registers,
// input and result stages. Depends on dlts_pkg, dlts_timing, dlts_affine.
//
//  channel | direction | tdata bits | contents
//  s_axis  | in        | 8          | phase_done
//  m_axis  | out       | 144        | phase, line, wait, irq, DMA flags, affine points
//  cfg     | in        | 56         | register write, index 0..5
//
// One transfer per cycle on each side while m_axis is not stalled; a result
// passes through the input register and then the result register.
// An input with phase_done low is consumed and gives no result.
// A stalled m_axis holds the result register and, once the input register
// is also full, drops s_axis_tready. Reset clears all state and registers.
`include "assert_macros.svh"
module display_line_timing_sequencer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [0] phase_done, [7:1] zero
    input  logic [dlts_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [1:0] phase_now, [9:2] line_count, [20:10] wait_length, [21] line_match,
    // [24:22] irq_raise, [25] hblank_dma, [26] vblank_dma, [27] render_line,
    // [55:28] bg2_x, [83:56] bg2_y, [111:84] bg3_x, [139:112] bg3_y, [143:140] zero
    output logic [dlts_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 cfg_we,
    input  logic [dlts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dlts_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [7:0]  line_match_value_reg;
    logic [2:0]  irq_enables_reg;
    logic [31:0] bg2_deltas_reg;
    logic [31:0] bg3_deltas_reg;
    logic [55:0] bg2_ref_reg;
    logic [55:0] bg3_ref_reg;

    logic        in_valid_reg, in_valid_next;
    logic        in_done_reg;
    logic        out_valid_reg, out_valid_next;
    logic [dlts_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic        s_xfer;
    logic        out_free;
    logic        advance;
    logic        step;

    dlts_pkg::tm_result_t tm_result;
    dlts_pkg::aff_ctrl_t  aff_ctrl;
    dlts_pkg::acc_vec_t   acc_next;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign step          = advance && in_done_reg;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_match_value_reg <= 8'd0;
            irq_enables_reg      <= 3'd0;
            bg2_deltas_reg       <= 32'd0;
            bg3_deltas_reg       <= 32'd0;
            bg2_ref_reg          <= 56'd0;
            bg3_ref_reg          <= 56'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dlts_pkg::REG_LINE_MATCH: line_match_value_reg <= cfg_data[7:0];
                dlts_pkg::REG_IRQ_EN:     irq_enables_reg      <= cfg_data[2:0];
                dlts_pkg::REG_BG2_DELTA:  bg2_deltas_reg       <= cfg_data[31:0];
                dlts_pkg::REG_BG3_DELTA:  bg3_deltas_reg       <= cfg_data[31:0];
                dlts_pkg::REG_BG2_REF:    bg2_ref_reg          <= cfg_data[55:0];
                dlts_pkg::REG_BG3_REF:    bg3_ref_reg          <= cfg_data[55:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        priority if (s_xfer)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        priority if (step)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_done_reg  <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            if (s_xfer)
                in_done_reg <= s_axis_tdata[0];
            if (step)
                out_data_reg <= dlts_pkg::pack_result(tm_result, acc_next);
        end
    end

    dlts_timing u_timing
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .line_match_value (line_match_value_reg),
        .irq_enables      (irq_enables_reg),
        .result           (tm_result),
        .aff_ctrl         (aff_ctrl)
    );

    dlts_affine u_affine
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .aff_ctrl        (aff_ctrl),
        .bg2_line_deltas (bg2_deltas_reg),
        .bg3_line_deltas (bg3_deltas_reg),
        .bg2_reference   (bg2_ref_reg),
        .bg3_reference   (bg3_ref_reg),
        .acc_next        (acc_next)
    );

    `ASSERT_CHECK(a_step_gives_result, step |=> out_valid_reg, "accepted step left no result")
    `ASSERT_CHECK(a_render_in_hblank, out_valid_reg && out_data_reg[27] |-> out_data_reg[1:0] == dlts_pkg::PH_HBLANK && out_data_reg[25], "render flag outside hblank entry")
    `ASSERT_CHECK(a_vblank_has_dma, out_valid_reg && out_data_reg[1:0] == dlts_pkg::PH_VBLANK |-> out_data_reg[26], "vblank result without vblank DMA flag")

endmodule

FILE: tb/tb_top.sv
// Testbench for display_line_timing_sequencer: drives phase-done transfers under random
// bursts and stalls, predicts each timing result and checks it field by field.
// Depends on dlts_pkg and the display_line_timing_sequencer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dlts_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int END_DRAIN_LIMIT = 4000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int LONG_HOLD       = 90;
    localparam int MAX_PRINTS      = 40;
    localparam int PHASE_EVENTS    = 206;
    localparam int NUM_PHASES      = 5;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        bit done;
        bit hold_for_drain;
    } line_mark_t;

    typedef struct {
        tm_result_t r;
        acc_vec_t   acc;
    } line_timing_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    display_line_timing_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // register shadow
    logic [7:0]            match_line = '0;
    logic [2:0]            irq_en = '0;
    logic [31:0]           bg2_delta = '0;
    logic [31:0]           bg3_delta = '0;
    logic [CFG_DATA_W-1:0] bg2_ref = '0;
    logic [CFG_DATA_W-1:0] bg3_ref = '0;

    // predicted sequencer state
    logic [1:0] scan_phase = PH_DRAW;
    logic [7:0] line_ctr = '0;
    logic       hdma = 1'b0;
    logic       vdma = 1'b0;
    acc_vec_t   aff_pos = '0;

    line_mark_t   line_marks[$];
    line_timing_t timing_due[$];
    line_timing_t predicted;

    int  mismatches = 0;
    int  events_sent = 0;
    int  idle_sent = 0;
    int  results_seen = 0;
    int  reg_writes = 0;
    int  vblank_entries = 0;
    int  frame_wraps = 0;
    int  match_pulses = 0;
    int  cycles = 0;
    int  gap_left = 0;
    int  burst_left = 0;
    bit  taken = 1'b0;
    int  hold_left = 0;
    int  next_hold_at = 150;
    int  mode_left = 0;
    int  ready_mode = 0;
    int  stall_tick = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     timing_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h", results_seen, what,
                     got, want);
    endtask

    function automatic logic [ACC_W-1:0] widen_step(input logic [15:0] d);
        return {{(ACC_W-16){d[15]}}, d};
    endfunction

    // advance the line timing by one elapsed phase and return the result it gives
    function automatic line_timing_t advance_timing();
        line_timing_t ev;
        logic [8:0]   next_line;
        logic         hit;
        ev.r = '0;
        hit = (line_ctr == match_line);
        ev.r.line_match = hit;
        case (scan_phase)
            PH_DRAW:
            begin
                hdma = 1'b1;
                scan_phase = PH_HBLANK;
                ev.r.wait_length = WAIT_HBLANK;
                aff_pos[0] = aff_pos[0] + widen_step(bg2_delta[15:0]);
                aff_pos[1] = aff_pos[1] + widen_step(bg2_delta[31:16]);
                aff_pos[2] = aff_pos[2] + widen_step(bg3_delta[15:0]);
                aff_pos[3] = aff_pos[3] + widen_step(bg3_delta[31:16]);
                ev.r.irq_raise[IRQ_HBLANK] = irq_en[IRQ_HBLANK];
                ev.r.render_line = 1'b1;
            end
            PH_HBLANK:
            begin
                next_line = line_ctr + 9'd1;
                line_ctr = next_line[7:0];
                ev.r.irq_raise[IRQ_MATCH] = hit & irq_en[IRQ_MATCH];
                hdma = 1'b0;
                if (next_line == VISIBLE_LINES)
                begin
                    aff_pos[0] = bg2_ref[ACC_W-1:0];
                    aff_pos[1] = bg2_ref[2*ACC_W-1:ACC_W];
                    aff_pos[2] = bg3_ref[ACC_W-1:0];
                    aff_pos[3] = bg3_ref[2*ACC_W-1:ACC_W];
                    vdma = 1'b1;
                    scan_phase = PH_VBLANK;
                    ev.r.wait_length = WAIT_VBLANK;
                    ev.r.irq_raise[IRQ_VBLANK] = irq_en[IRQ_VBLANK];
                    vblank_entries++;
                end
                else
                begin
                    scan_phase = PH_DRAW;
                    ev.r.wait_length = WAIT_DRAW;
                end
            end
            default:
            begin
                next_line = line_ctr + 9'd1;
                line_ctr = next_line[7:0];
                ev.r.irq_raise[IRQ_MATCH] = hit & irq_en[IRQ_MATCH];
                if (next_line == TOTAL_LINES)
                begin
                    vdma = 1'b0;
                    scan_phase = PH_DRAW;
                    ev.r.wait_length = WAIT_DRAW;
                    line_ctr = '0;
                    frame_wraps++;
                end
                else
                begin
                    scan_phase = PH_VBLANK;
                    ev.r.wait_length = WAIT_VBLANK;
                end
            end
        endcase
        if (ev.r.irq_raise[IRQ_MATCH])
            match_pulses++;
        ev.r.phase_now = scan_phase;
        ev.r.line_count = line_ctr;
        ev.r.hblank_dma = hdma;
        ev.r.vblank_dma = vdma;
        ev.acc = aff_pos;
        return ev;
    endfunction

    task automatic check_timing(input logic [OUT_TDATA_W-1:0] bus);
        line_timing_t want;
        tm_result_t   r;
        acc_vec_t     a;
        if (timing_due.size() == 0)
        begin
            flag_mismatch("unexpected transfer", bus[63:0], 0);
            return;
        end
        want = timing_due.pop_front();
        r = bus[$bits(tm_result_t)-1:0];
        a = bus[$bits(tm_result_t) +: NUM_ACC*ACC_W];
        if (r.phase_now !== want.r.phase_now)
            flag_mismatch("phase_now", r.phase_now, want.r.phase_now);
        if (r.line_count !== want.r.line_count)
            flag_mismatch("line_count", r.line_count, want.r.line_count);
        if (r.wait_length !== want.r.wait_length)
            flag_mismatch("wait_length", r.wait_length, want.r.wait_length);
        if (r.line_match !== want.r.line_match)
            flag_mismatch("line_match", r.line_match, want.r.line_match);
        if (r.irq_raise !== want.r.irq_raise)
            flag_mismatch("irq_raise", r.irq_raise, want.r.irq_raise);
        if (r.hblank_dma !== want.r.hblank_dma)
            flag_mismatch("hblank_dma", r.hblank_dma, want.r.hblank_dma);
        if (r.vblank_dma !== want.r.vblank_dma)
            flag_mismatch("vblank_dma", r.vblank_dma, want.r.vblank_dma);
        if (r.render_line !== want.r.render_line)
            flag_mismatch("render_line", r.render_line, want.r.render_line);
        if (a[0] !== want.acc[0])
            flag_mismatch("bg2_x", a[0], want.acc[0]);
        if (a[1] !== want.acc[1])
            flag_mismatch("bg2_y", a[1], want.acc[1]);
        if (a[2] !== want.acc[2])
            flag_mismatch("bg3_x", a[2], want.acc[2]);
        if (a[3] !== want.acc[3])
            flag_mismatch("bg3_y", a[3], want.acc[3]);
    endtask

    // sender: offer queued marks in bursts, hold each until its transfer
    always @(posedge clk)
    begin
        taken = 1'b0;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            if (s_axis_tdata[0])
            begin
                predicted = advance_timing();
                timing_due.push_back(predicted);
                events_sent++;
            end
            else
                idle_sent++;
            void'(line_marks.pop_front());
            taken = 1'b1;
        end
        @(negedge clk);
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || taken)
        begin
            if (gap_left > 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left--;
            end
            else if (line_marks.size() == 0 ||
                     (line_marks[0].hold_for_drain && timing_due.size() != 0))
                s_axis_tvalid <= 1'b0;
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {{(IN_TDATA_W-1){1'b0}}, line_marks[0].done};
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 9) < 4)
                        gap_left = 0;
                    else if ($urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(1, 20);
                    else
                        gap_left = $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
        end
    end

    // receiver: check each transfer, stall on its own pattern
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            check_timing(m_axis_tdata);
            results_seen++;
        end
        @(negedge clk);
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            stall_tick++;
            if (hold_left == 0 && results_seen >= next_hold_at)
            begin
                hold_left = LONG_HOLD;
                next_hold_at += 550;
            end
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                case (ready_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ((stall_tick % 5) != 0);
                endcase
        end
    end

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_LINE_MATCH: match_line = val[7:0];
            REG_IRQ_EN:     irq_en = val[2:0];
            REG_BG2_DELTA:  bg2_delta = val[31:0];
            REG_BG3_DELTA:  bg3_delta = val[31:0];
            REG_BG2_REF:    bg2_ref = val;
            REG_BG3_REF:    bg3_ref = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_quiet(input int bound);
        int spins;
        spins = 0;
        while (line_marks.size() != 0)
            @(posedge clk);
        while (timing_due.size() != 0 && spins < bound)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_marks(input int events);
        line_mark_t m;
        int         placed;
        int         pause_at;
        placed = 0;
        pause_at = $urandom_range(events / 4, 3 * events / 4);
        while (placed < events)
        begin
            m.done = ($urandom_range(0, 19) != 0);
            m.hold_for_drain = m.done && (placed == pause_at);
            line_marks.push_back(m);
            if (m.done)
                placed++;
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_wide();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[CFG_DATA_W-1:0];
    endfunction

    initial
    begin
        line_mark_t m;
        logic [CFG_DATA_W-1:0] d2;
        logic [CFG_DATA_W-1:0] d3;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes of deltas and start points, every interrupt source enabled
        program_reg(REG_LINE_MATCH, 0);
        program_reg(REG_IRQ_EN, 3'b111);
        program_reg(REG_BG2_DELTA, {16'h7FFF, 16'h8000});
        program_reg(REG_BG3_DELTA, {16'hFFFF, 16'h0001});
        program_reg(REG_BG2_REF, {28'h7FFFFFF, 28'h8000000});
        program_reg(REG_BG3_REF, {28'hFFFFFFF, 28'h0000001});
        program_reg(REG_SPARE_LO, random_wide());
        program_reg(REG_SPARE_HI, random_wide());
        end_writes();
        for (int k = 0; k < 20; k++)
        begin
            m.done = !(k == 3 || k == 10 || k == 15);
            m.hold_for_drain = (k == 8);
            line_marks.push_back(m);
        end
        wait_quiet(CYCLE_LIMIT);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                1: program_reg(REG_LINE_MATCH, 8'hFF);
                3: program_reg(REG_LINE_MATCH, 8'h00);
                default: program_reg(REG_LINE_MATCH, (line_ctr + $urandom_range(2, 90)) % 256);
            endcase
            case (ph)
                0: program_reg(REG_IRQ_EN, 3'b111);
                1: program_reg(REG_IRQ_EN, 3'b000);
                default: program_reg(REG_IRQ_EN, $urandom_range(0, 7));
            endcase
            case (ph)
                1:
                begin
                    d2 = 32'h8000_8000;
                    d3 = 32'h8000_8000;
                end
                3:
                begin
                    d2 = 32'h7FFF_7FFF;
                    d3 = 32'h7FFF_7FFF;
                end
                default:
                begin
                    d2 = $urandom;
                    d3 = $urandom;
                end
            endcase
            program_reg(REG_BG2_DELTA, d2);
            program_reg(REG_BG3_DELTA, d3);
            case (ph)
                1:
                begin
                    d2 = {CFG_DATA_W{1'b1}};
                    d3 = '0;
                end
                3:
                begin
                    d2 = {28'h7FFFFFF, 28'h8000000};
                    d3 = {28'h8000000, 28'h7FFFFFF};
                end
                default:
                begin
                    d2 = random_wide();
                    d3 = random_wide();
                end
            endcase
            program_reg(REG_BG2_REF, d2);
            program_reg(REG_BG3_REF, d3);
            program_reg(ph[0] ? REG_SPARE_HI : REG_SPARE_LO, random_wide());
            end_writes();
            queue_marks(PHASE_EVENTS);
            wait_quiet(CYCLE_LIMIT);
        end

        wait_quiet(END_DRAIN_LIMIT);
        if (timing_due.size() != 0)
            flag_mismatch("results never delivered", timing_due.size(), 0);
        $display("Covered %0d line events and %0d idle marks, %0d results checked, %0d reg writes",
                 events_sent, idle_sent, results_seen, reg_writes);
        $display("Saw %0d vblank entries, %0d frame wraps, %0d line-match pulses, %0d mismatches",
                 vblank_entries, frame_wraps, match_pulses, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
